// File: hw/rtl/pose_finite_difference_velocity_assert.svh
// assertion macros for the pose finite difference velocity block
// used by the top level; expects signals clk and rst in scope
`ifndef POSE_FINITE_DIFFERENCE_VELOCITY_ASSERT_SVH
`define POSE_FINITE_DIFFERENCE_VELOCITY_ASSERT_SVH

// condition holds in the same cycle as the antecedent
`define PFDV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the antecedent
`define PFDV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/pfdv_pkg.sv
// shared constants, types and helper functions of the velocity block
// no dependencies; used by pfdv_div, the top level, the checker and the testbench
package pfdv_pkg;

  localparam int POS_FRAC_BITS  = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int TIME_W         = 63;
  localparam int MIN_W          = 30;
  localparam int NUM_W          = TIME_W + POS_FRAC_BITS + 1;
  localparam int DEN_W          = 33 + TIME_W;
  localparam int CNT_W          = $clog2(NUM_W);

  localparam logic [32:0]      NS_PER_SEC      = 33'd1000000000;
  localparam logic [MIN_W-1:0] MIN_INTERVAL_RST = 30'd1000;
  localparam logic             REG_MIN_INTERVAL = 1'b0;

  // 1e9 = 512 * 1953125; reciprocal is 2^52 / 1953125 rounded down
  localparam logic [20:0]      NS_PER_SEC_ODD  = 21'd1953125;
  localparam logic [31:0]      SEC_RECIP       = 32'd2305843009;

  // accumulator selectors of the quaternion product terms
  localparam logic [1:0] ACC_N  = 2'd0;
  localparam logic [1:0] ACC_V0 = 2'd1;
  localparam logic [1:0] ACC_V1 = 2'd2;
  localparam logic [1:0] ACC_V2 = 2'd3;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [1:0] dst;
    logic       a_is_q;
    logic [1:0] ai;
    logic [1:0] bi;
    logic       neg;
  } term_t;

  // terms of |p|^2 and vec(q * conj(p)), second operand always from p
  function automatic term_t quat_term(input logic [3:0] k);
    term_t t;
    case (k)
      4'd0:    t = '{ACC_N,  1'b0, 2'd0, 2'd0, 1'b0};
      4'd1:    t = '{ACC_N,  1'b0, 2'd1, 2'd1, 1'b0};
      4'd2:    t = '{ACC_N,  1'b0, 2'd2, 2'd2, 1'b0};
      4'd3:    t = '{ACC_N,  1'b0, 2'd3, 2'd3, 1'b0};
      4'd4:    t = '{ACC_V0, 1'b1, 2'd0, 2'd1, 1'b1};
      4'd5:    t = '{ACC_V0, 1'b1, 2'd1, 2'd0, 1'b0};
      4'd6:    t = '{ACC_V0, 1'b1, 2'd2, 2'd3, 1'b1};
      4'd7:    t = '{ACC_V0, 1'b1, 2'd3, 2'd2, 1'b0};
      4'd8:    t = '{ACC_V1, 1'b1, 2'd0, 2'd2, 1'b1};
      4'd9:    t = '{ACC_V1, 1'b1, 2'd1, 2'd3, 1'b0};
      4'd10:   t = '{ACC_V1, 1'b1, 2'd2, 2'd0, 1'b0};
      4'd11:   t = '{ACC_V1, 1'b1, 2'd3, 2'd1, 1'b1};
      4'd12:   t = '{ACC_V2, 1'b1, 2'd0, 2'd3, 1'b1};
      4'd13:   t = '{ACC_V2, 1'b1, 2'd1, 2'd2, 1'b1};
      4'd14:   t = '{ACC_V2, 1'b1, 2'd2, 2'd1, 1'b0};
      default: t = '{ACC_V2, 1'b1, 2'd3, 2'd0, 1'b0};
    endcase
    return t;
  endfunction

  // clamp a quotient magnitude and apply the sign
  function automatic logic [31:0] sat_quo(input logic [NUM_W-1:0] q, input logic neg);
    logic [NUM_W-1:0] lim;
    logic [31:0]      mag;
    lim = neg ? NUM_W'(33'h080000000) : NUM_W'(32'h7FFFFFFF);
    mag = (q > lim) ? lim[31:0] : q[31:0];
    return neg ? (32'd0 - mag) : mag;
  endfunction

endpackage

// File: hw/rtl/pfdv_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on pfdv_pkg for widths and the request/response structs
module pfdv_div (
  input  logic                clk,
  input  logic                rst,
  input  pfdv_pkg::div_req_t  req,
  output pfdv_pkg::div_rsp_t  rsp
);

  logic [pfdv_pkg::NUM_W-1:0] qn;
  logic [pfdv_pkg::DEN_W-1:0] rem;
  logic [pfdv_pkg::DEN_W-1:0] den;
  logic [pfdv_pkg::CNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [pfdv_pkg::DEN_W+1:0] diff;

  assign diff = {1'b0, rem, qn[pfdv_pkg::NUM_W-1]} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        qn   <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[pfdv_pkg::DEN_W+1]) begin
          rem <= diff[pfdv_pkg::DEN_W-1:0];
          qn  <= {qn[pfdv_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem <= {rem[pfdv_pkg::DEN_W-2:0], qn[pfdv_pkg::NUM_W-1]};
          qn  <= {qn[pfdv_pkg::NUM_W-2:0], 1'b0};
        end
        if (cnt == pfdv_pkg::CNT_W'(pfdv_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = qn;
  assign rsp.rem  = rem;

endmodule

// File: hw/rtl/pose_finite_difference_velocity.sv
// pose finite difference velocity: one result per non-paused request.
// one request at a time: the next request is taken only after the last result is
// registered at the output, later if the receiver holds a pending result.
// when a velocity is due, six quotients run one after another on the shared bit-serial divider.
// rst is synchronous: clears the sequencer, previous sample and output valid,
// and loads min_interval_ns with 1000.
module pose_finite_difference_velocity (
  input  logic         clk,
  input  logic         rst,
  // apb configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // pose samples
  input  logic         s_tvalid,
  output logic         s_tready,
  // sim_time_ns[62:0], pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, pad
  input  logic [223:0] s_tdata,
  // paused
  input  logic [0:0]   s_tuser,
  // velocity results
  output logic         m_tvalid,
  input  logic         m_tready,
  // stamp_sec[33:0], stamp_nsec, lin_vel_x/y/z, ang_vel_x/y/z
  output logic [255:0] m_tdata,
  // vel_valid
  output logic [0:0]   m_tuser
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_SEC_LO, S_SEC_SUM, S_SEC_REM, S_STAMP, S_LIN_MUL, S_LIN_START,
    S_LIN_DIV, S_QMAC, S_QFIX, S_DEN_LO, S_DEN_HI, S_DEN_SUM, S_ANG_MUL, S_ANG_START,
    S_ANG_DIV, S_OUT
  } state_t;

  state_t state;

  logic [pfdv_pkg::MIN_W-1:0]  min_int;
  logic [pfdv_pkg::TIME_W-1:0] t_r, prev_t, dt;
  logic                        t_gt, have_prev, vel_ok;
  logic signed [31:0]          pos_r [3];
  logic signed [31:0]          prev_pos [3];
  logic signed [15:0]          q_r [4];
  logic signed [15:0]          prev_q [4];
  logic signed [32:0]          d_r [3];
  logic [32:0]                 dmag [3];
  logic                        dneg [3];
  logic signed [33:0]          nacc;
  logic signed [33:0]          vacc [3];
  logic [32:0]                 vmag [3];
  logic                        vneg [3];
  logic [pfdv_pkg::DEN_W-1:0]  den_r;
  logic [33:0]                 sec_r;
  logic [29:0]                 nsec_r;
  logic [31:0]                 lin_r [3];
  logic [31:0]                 ang_r [3];
  logic [3:0]                  cnt;
  logic                        ph;
  logic [58:0]                 sec_hi;
  logic [85:0]                 sec_sum;
  logic [33:0]                 q_est;
  logic [31:0]                 rem_raw;
  logic [20:0]                 rem_adj;

  logic signed [33:0]          mul_a;
  logic signed [32:0]          mul_b;
  logic signed [66:0]          prod;
  pfdv_pkg::term_t             tm;
  pfdv_pkg::div_req_t          dreq;
  pfdv_pkg::div_rsp_t          drsp;
  logic signed [33:0]          addend;
  logic signed [33:0]          v_sel [3];
  logic                        cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == pfdv_pkg::REG_MIN_INTERVAL);
  assign prdata   = (paddr[2] == pfdv_pkg::REG_MIN_INTERVAL) ? {2'b00, min_int} : 32'd0;
  assign s_tready = (state == S_IDLE);

  assign tm     = pfdv_pkg::quat_term(cnt);
  assign addend = tm.neg ? -prod[33:0] : prod[33:0];

  // seconds estimate from (t >> 9) times the scaled reciprocal, at most one low
  assign sec_sum = {sec_hi, 27'd0} + {27'd0, prod[58:0]};
  assign rem_raw = t_r[40:9] - prod[31:0];
  assign rem_adj = rem_raw[20:0] - pfdv_pkg::NS_PER_SEC_ODD;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CHECK: begin
        mul_a = {7'd0, t_r[62:36]};
        mul_b = {1'b0, pfdv_pkg::SEC_RECIP};
      end
      S_SEC_LO: begin
        mul_a = {7'd0, t_r[35:9]};
        mul_b = {1'b0, pfdv_pkg::SEC_RECIP};
      end
      S_SEC_REM: begin
        mul_a = {2'b00, q_est[31:0]};
        mul_b = {12'd0, pfdv_pkg::NS_PER_SEC_ODD};
      end
      S_LIN_MUL: begin
        mul_a = {1'b0, dmag[cnt[1:0]]};
        mul_b = pfdv_pkg::NS_PER_SEC;
      end
      S_QMAC: begin
        mul_a = tm.a_is_q ? 34'(q_r[tm.ai]) : 34'(prev_q[tm.ai]);
        mul_b = 33'(prev_q[tm.bi]);
      end
      S_DEN_LO: begin
        mul_a = nacc;
        mul_b = {1'b0, dt[31:0]};
      end
      S_DEN_HI: begin
        mul_a = nacc;
        mul_b = {2'b00, dt[62:32]};
      end
      S_ANG_MUL: begin
        mul_a = {1'b0, vmag[cnt[1:0]]};
        mul_b = pfdv_pkg::NS_PER_SEC;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // divider request select
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    case (state)
      S_LIN_START: begin
        dreq.start = 1'b1;
        dreq.num   = pfdv_pkg::NUM_W'(prod[62:0]);
        dreq.den   = pfdv_pkg::DEN_W'(dt);
      end
      S_ANG_START: begin
        dreq.start = 1'b1;
        dreq.num   = {prod[62:0], {(pfdv_pkg::POS_FRAC_BITS + 1){1'b0}}};
        dreq.den   = den_r;
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_sel[i] = (nacc == '0) ? 34'(q_r[i+1]) : vacc[i];
    end
  end

  pfdv_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      min_int   <= pfdv_pkg::MIN_INTERVAL_RST;
      have_prev <= 1'b0;
      prev_t    <= '0;
      for (int i = 0; i < 3; i++) prev_pos[i] <= '0;
      for (int i = 0; i < 4; i++) prev_q[i] <= '0;
      m_tvalid  <= 1'b0;
      cnt       <= '0;
      ph        <= 1'b0;
    end else begin
      if (cfg_wr) min_int <= pwdata[pfdv_pkg::MIN_W-1:0];
      if (m_tvalid && m_tready && (state != S_OUT)) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && !s_tuser[0]) begin
            t_r      <= s_tdata[62:0];
            pos_r[0] <= s_tdata[94:63];
            pos_r[1] <= s_tdata[126:95];
            pos_r[2] <= s_tdata[158:127];
            q_r[0]   <= s_tdata[174:159];
            q_r[1]   <= s_tdata[190:175];
            q_r[2]   <= s_tdata[206:191];
            q_r[3]   <= s_tdata[222:207];
            dt       <= s_tdata[62:0] - prev_t;
            t_gt     <= s_tdata[62:0] > prev_t;
            d_r[0]   <= 33'($signed(s_tdata[94:63])) - 33'(prev_pos[0]);
            d_r[1]   <= 33'($signed(s_tdata[126:95])) - 33'(prev_pos[1]);
            d_r[2]   <= 33'($signed(s_tdata[158:127])) - 33'(prev_pos[2]);
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          vel_ok <= have_prev && t_gt && (dt > pfdv_pkg::TIME_W'(min_int));
          for (int i = 0; i < 3; i++) begin
            dneg[i] <= d_r[i][32];
            dmag[i] <= d_r[i][32] ? 33'(-d_r[i]) : 33'(d_r[i]);
          end
          state <= S_SEC_LO;
        end
        S_SEC_LO: begin
          sec_hi <= prod[58:0];
          state  <= S_SEC_SUM;
        end
        S_SEC_SUM: begin
          q_est <= sec_sum[85:52];
          state <= S_SEC_REM;
        end
        S_SEC_REM: state <= S_STAMP;
        S_STAMP: begin
          if (rem_raw >= {11'd0, pfdv_pkg::NS_PER_SEC_ODD}) begin
            sec_r  <= q_est + 34'd1;
            nsec_r <= {rem_adj, t_r[8:0]};
          end else begin
            sec_r  <= q_est;
            nsec_r <= {rem_raw[20:0], t_r[8:0]};
          end
          cnt   <= '0;
          state <= vel_ok ? S_LIN_MUL : S_OUT;
        end
        S_LIN_MUL:   state <= S_LIN_START;
        S_LIN_START: state <= S_LIN_DIV;
        S_LIN_DIV: begin
          if (drsp.done) begin
            lin_r[cnt[1:0]] <= pfdv_pkg::sat_quo(drsp.quo, dneg[cnt[1:0]]);
            if (cnt == 4'd2) begin
              cnt  <= '0;
              ph   <= 1'b0;
              nacc <= '0;
              for (int i = 0; i < 3; i++) vacc[i] <= '0;
              state <= S_QMAC;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= S_LIN_MUL;
            end
          end
        end
        S_QMAC: begin
          // phase 0 forms the product, phase 1 adds it in
          ph <= ~ph;
          if (ph) begin
            case (tm.dst)
              pfdv_pkg::ACC_N:  nacc    <= nacc + addend;
              pfdv_pkg::ACC_V0: vacc[0] <= vacc[0] + addend;
              pfdv_pkg::ACC_V1: vacc[1] <= vacc[1] + addend;
              default:          vacc[2] <= vacc[2] + addend;
            endcase
            cnt <= cnt + 1'b1;
            if (cnt == 4'd15) state <= S_QFIX;
          end
        end
        S_QFIX: begin
          // zero norm previous quaternion: inverse is the identity
          if (nacc == '0) nacc <= 34'(1 << pfdv_pkg::QUAT_FRAC_BITS);
          for (int i = 0; i < 3; i++) begin
            vneg[i] <= v_sel[i][33];
            vmag[i] <= v_sel[i][33] ? 33'(-v_sel[i]) : 33'(v_sel[i]);
          end
          state <= S_DEN_LO;
        end
        S_DEN_LO: state <= S_DEN_HI;
        S_DEN_HI: begin
          den_r <= pfdv_pkg::DEN_W'(prod[64:0]);
          state <= S_DEN_SUM;
        end
        S_DEN_SUM: begin
          den_r <= den_r + {prod[63:0], 32'd0};
          cnt   <= '0;
          state <= S_ANG_MUL;
        end
        S_ANG_MUL:   state <= S_ANG_START;
        S_ANG_START: state <= S_ANG_DIV;
        S_ANG_DIV: begin
          if (drsp.done) begin
            ang_r[cnt[1:0]] <= pfdv_pkg::sat_quo(drsp.quo, vneg[cnt[1:0]]);
            if (cnt == 4'd2) begin
              state <= S_OUT;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= S_ANG_MUL;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= vel_ok;
            m_tdata  <= vel_ok ?
                        {ang_r[2], ang_r[1], ang_r[0], lin_r[2], lin_r[1], lin_r[0],
                         nsec_r, sec_r} :
                        {192'd0, nsec_r, sec_r};
            prev_t    <= t_r;
            for (int i = 0; i < 3; i++) prev_pos[i] <= pos_r[i];
            for (int i = 0; i < 4; i++) prev_q[i] <= q_r[i];
            have_prev <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "pose_finite_difference_velocity_assert.svh"

  `PFDV_ASSERT_NEXT(a_out_hold, (state == S_OUT) && m_tvalid && !m_tready, state == S_OUT, "result overwritten while pending")
  `PFDV_ASSERT_NOW(a_zero_vel, m_tvalid && !m_tuser[0], m_tdata[255:64] == 192'd0, "velocity nonzero without vel_valid")
  `PFDV_ASSERT_NEXT(a_start, s_tvalid && s_tready && !s_tuser[0], state == S_CHECK, "request not started")
  `PFDV_ASSERT_NOW(a_nsec_range, m_tvalid, m_tdata[63:34] < 30'd1000000000, "nanosecond remainder out of range")

endmodule

// File: verif/pfdv_checker.sv
// checker for the pose finite difference velocity block: watches the apb port and both
// streams, predicts each result from its own copy of the block state and compares
// depends on pfdv_pkg for the register index, reset interval and fraction width constants
module pfdv_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [223:0] s_tdata,
  input  logic [0:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [255:0] m_tdata,
  input  logic [0:0]   m_tuser,
  output int           fail_count,
  output int           pending,
  output int           vel_count,
  output int           still_count
);

  typedef struct {
    logic [33:0] sec;
    logic [29:0] nsec;
    logic        vel_ok;
    logic [31:0] lin [3];
    logic [31:0] ang [3];
  } pose_rate_t;

  pose_rate_t rate_q[$];

  logic [29:0]    min_step;
  bit             have_prev;
  logic [62:0]    prev_t;
  longint         prev_p [3];
  longint         prev_quat [4];

  // truncate toward zero, then clamp to the 32-bit range
  function automatic logic [31:0] clamp_ratio(logic [127:0] num, logic [127:0] den, bit neg);
    logic [127:0] quo;
    logic [127:0] lim;
    logic [31:0]  mag;
    quo = num / den;
    lim = neg ? 128'h80000000 : 128'h7FFFFFFF;
    mag = (quo > lim) ? lim[31:0] : quo[31:0];
    return neg ? (32'd0 - mag) : mag;
  endfunction

  function automatic pose_rate_t predict_rate(logic [223:0] d);
    pose_rate_t r;
    logic [62:0]  t;
    logic [62:0]  dt;
    longint       p [3];
    longint       q [4];
    longint       v [3];
    longint       n;
    longint       dp;
    logic [127:0] den;
    t = d[62:0];
    for (int i = 0; i < 3; i++) p[i] = longint'(signed'(d[63 + 32*i +: 32]));
    for (int i = 0; i < 4; i++) q[i] = longint'(signed'(d[159 + 16*i +: 16]));
    r.sec    = 34'(t / 63'd1000000000);
    r.nsec   = 30'(t % 63'd1000000000);
    r.vel_ok = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r.lin[i] = '0;
      r.ang[i] = '0;
    end
    if (have_prev && t > prev_t && (t - prev_t) > 63'(min_step)) begin
      dt = t - prev_t;
      r.vel_ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
        dp = p[i] - prev_p[i];
        r.lin[i] = clamp_ratio(128'(dp < 0 ? -dp : dp) * 128'd1000000000, 128'(dt), dp < 0);
      end
      n = prev_quat[0]*prev_quat[0] + prev_quat[1]*prev_quat[1]
        + prev_quat[2]*prev_quat[2] + prev_quat[3]*prev_quat[3];
      if (n == 0) begin
        // identity inverse for a zero previous orientation
        v[0] = q[1];
        v[1] = q[2];
        v[2] = q[3];
        n = longint'(1) << pfdv_pkg::QUAT_FRAC_BITS;
      end else begin
        v[0] = -q[0]*prev_quat[1] + q[1]*prev_quat[0] - q[2]*prev_quat[3] + q[3]*prev_quat[2];
        v[1] = -q[0]*prev_quat[2] + q[1]*prev_quat[3] + q[2]*prev_quat[0] - q[3]*prev_quat[1];
        v[2] = -q[0]*prev_quat[3] - q[1]*prev_quat[2] + q[2]*prev_quat[1] + q[3]*prev_quat[0];
      end
      den = 128'(n) * 128'(dt);
      for (int i = 0; i < 3; i++)
        r.ang[i] = clamp_ratio((128'(v[i] < 0 ? -v[i] : v[i]) * 128'd1000000000)
                               << (pfdv_pkg::POS_FRAC_BITS + 1), den, v[i] < 0);
    end
    prev_t = t;
    for (int i = 0; i < 3; i++) prev_p[i] = p[i];
    for (int i = 0; i < 4; i++) prev_quat[i] = q[i];
    have_prev = 1'b1;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t mismatch %s: expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    pose_rate_t e;
    if (rst) begin
      min_step  <= pfdv_pkg::MIN_INTERVAL_RST;
      have_prev  = 1'b0;
      prev_t     = '0;
      for (int i = 0; i < 3; i++) prev_p[i] = 0;
      for (int i = 0; i < 4; i++) prev_quat[i] = 0;
      rate_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'(4 * pfdv_pkg::REG_MIN_INTERVAL))
        min_step <= pwdata[29:0];
      if (s_tvalid && s_tready && !s_tuser[0])
        rate_q.push_back(predict_rate(s_tdata));
      if (m_tvalid && m_tready) begin
        if (rate_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result %h", $time, m_tdata);
        end else begin
          e = rate_q.pop_front();
          if (e.vel_ok) vel_count++;
          else still_count++;
          check_field("stamp_sec", 64'(e.sec), 64'(m_tdata[33:0]));
          check_field("stamp_nsec", 64'(e.nsec), 64'(m_tdata[63:34]));
          check_field("vel_valid", 64'(e.vel_ok), 64'(m_tuser[0]));
          for (int i = 0; i < 3; i++) begin
            check_field($sformatf("lin_vel[%0d]", i), 64'(e.lin[i]), 64'(m_tdata[64 + 32*i +: 32]));
            check_field($sformatf("ang_vel[%0d]", i), 64'(e.ang[i]), 64'(m_tdata[160 + 32*i +: 32]));
          end
        end
      end
    end
    pending <= rate_q.size();
  end

  initial begin
    fail_count  = 0;
    pending     = 0;
    vel_count   = 0;
    still_count = 0;
  end

endmodule

// File: verif/tb_pose_finite_difference_velocity.sv
// testbench top for pose_finite_difference_velocity: clock, reset, apb writes, pose request
// stimulus with random idling and the verdict; depends on the dut, pfdv_pkg and pfdv_checker
module tb_pose_finite_difference_velocity;

  localparam int STALL_LIMIT = 30000;

  logic         clk;
  logic         rst;
  logic         psel, penable, pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid, s_tready;
  logic [223:0] s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid, m_tready;
  logic [255:0] m_tdata;
  logic [0:0]   m_tuser;

  int fail_count, pending, vel_count, still_count;
  int tx_idle_pct, rx_idle_pct;
  int hold_rx;
  int quiet_cycles;
  int sent;

  // generator state: the pose of the next request
  logic [62:0] cur_t;
  logic [31:0] cur_p [3];
  logic [15:0] cur_q [4];
  logic [29:0] cur_min;

  pose_finite_difference_velocity dut (.*);

  pfdv_checker chk (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .fail_count, .pending, .vel_count, .still_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_rx > 0) begin
      m_tready <= 1'b0;
      hold_rx  <= hold_rx - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("status: fail");
      $finish;
    end
  end

  // s_tvalid stays high after a request so the next one can follow back to back
  task automatic send_pose(bit paused);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= paused;
    s_tdata  <= {1'b0, cur_q[3], cur_q[2], cur_q[1], cur_q[0],
                 cur_p[2], cur_p[1], cur_p[0], cur_t};
    #1;
    while (!s_tready) @(negedge clk) #1;
    @(negedge clk);
    sent++;
  endtask

  task automatic write_min_step(logic [29:0] value);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // paused requests produce no result and are not counted in pending
    repeat (700) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * pfdv_pkg::REG_MIN_INTERVAL);
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_min = value;
  endtask

  task automatic set_pose(logic [62:0] t, logic [31:0] p, logic [15:0] qw, logic [15:0] qv);
    cur_t = t;
    for (int i = 0; i < 3; i++) cur_p[i] = p;
    cur_q[0] = qw;
    for (int i = 1; i < 4; i++) cur_q[i] = qv;
  endtask

  // next random pose: mostly a plausible motion, sometimes odd steps and wild values
  task automatic next_random_pose();
    int sel;
    sel = $urandom_range(19);
    case (sel)
      0:       cur_t = cur_t - 63'($urandom_range(5000));
      1:       cur_t = cur_t + 63'(cur_min);
      2:       cur_t = cur_t + 63'(cur_min) + 63'd1;
      3:       cur_t = 63'({$urandom, $urandom});
      4:       cur_t = cur_t + 63'($urandom_range(cur_min));
      5:       cur_t = 63'(cur_t + {$urandom, $urandom} % 63'h0000FFFFFFFFFFFF);
      default: cur_t = cur_t + 63'(cur_min) + 63'($urandom_range(1, 20000000));
    endcase
    for (int i = 0; i < 3; i++)
      if ($urandom_range(9) == 0) cur_p[i] = $urandom;
      else cur_p[i] = cur_p[i] + 32'(signed'(20'($urandom)));
    sel = $urandom_range(9);
    for (int i = 0; i < 4; i++) begin
      if (sel == 0) cur_q[i] = '0;
      else if (sel == 1) cur_q[i] = 16'($urandom);
      else if (sel < 5) cur_q[i] = cur_q[i] + 16'(signed'(9'($urandom)));
      else cur_q[i] = 16'($urandom_range(32768)) - 16'd16384;
    end
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) begin
      next_random_pose();
      send_pose($urandom_range(15) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    m_tready = 1'b0;
    tx_idle_pct = 17; rx_idle_pct = 47;
    hold_rx = 0; quiet_cycles = 0; sent = 0;
    cur_min = 30'd1000;
    set_pose('0, '0, '0, '0);
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: first sample has no predecessor
    set_pose(63'd0, 32'h7FFFFFFF, 16'h4000, 16'h4000);
    send_pose(1'b0);
    set_pose(63'd1001, 32'h80000000, 16'h7FFF, 16'h8000);
    send_pose(1'b0);
    // step equal to the minimum, then one past it
    set_pose(63'd2001, 32'h00010000, 16'h8000, 16'h7FFF);
    send_pose(1'b0);
    set_pose(63'd3002, 32'h7FFFFFFF, 16'h7FFF, 16'h8000);
    send_pose(1'b0);
    // paused request must leave no trace
    set_pose(63'd9000000, 32'h12345678, 16'h0000, 16'h0000);
    send_pose(1'b1);
    // time going backward, then a repeated time
    set_pose(63'd1000, 32'h00000000, 16'h4000, 16'h0000);
    send_pose(1'b0);
    send_pose(1'b0);
    set_pose(63'd5000000, 32'h00020000, 16'h3FFF, 16'h0100);
    send_pose(1'b0);
    set_pose(63'd6000000, 32'hFFFE0000, 16'h3F00, 16'hFF00);
    send_pose(1'b0);
    set_pose(63'h7FFFFFFFFFFFFFFF, 32'h00000001, 16'h0000, 16'h4000);
    send_pose(1'b0);
    set_pose(63'h7FFFFFFFFFFFFFFF - 63'd999, 32'h00000000, 16'hC000, 16'h0000);
    send_pose(1'b0);
    set_pose(63'd999999999, 32'h00000000, 16'h4000, 16'h0000);
    send_pose(1'b0);
    set_pose(63'd1000000000 + 63'd999999999, 32'h00008000, 16'h4000, 16'h0001);
    send_pose(1'b0);

    write_min_step(30'd0);
    set_pose(cur_t + 63'd1, 32'h00000010, 16'h4000, 16'h0000);
    send_pose(1'b0);
    random_phase(110);
    // long receiver hold-off while requests keep coming
    hold_rx = 3000;
    random_phase(110);
    // let everything drain before going on
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);

    tx_idle_pct = 47; rx_idle_pct = 17;
    write_min_step(30'd1000000000);
    random_phase(220);

    tx_idle_pct = 0; rx_idle_pct = 0;
    write_min_step(30'($urandom_range(1, 100000)));
    random_phase(220);

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (1000) @(negedge clk);
    $display("sent %0d pose requests over four minimum step settings", sent);
    $display("results with velocity %0d, without %0d", vel_count, still_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
